FILE: rtl/identifier_mention_scanner_macros.svh
// ----------------------------------------------------------------------------
// identifier_mention_scanner_macros
// assertion shorthands used by the scanner top level
// ----------------------------------------------------------------------------
`ifndef IDENTIFIER_MENTION_SCANNER_MACROS_SVH
`define IDENTIFIER_MENTION_SCANNER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define IMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define IMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ims_pkg.sv
// ----------------------------------------------------------------------------
// ims_pkg
// shared types, byte codes and helpers of the identifier mention scanner
// ----------------------------------------------------------------------------
package ims_pkg;

    localparam int NAME_BYTES = 16;

    localparam logic [7:0] CHAR_QUOTE      = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH  = 8'h5c;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CHAR_PERCENT    = 8'h25;

    localparam logic [1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [1:0] REG_NAME_LEN  = 2'd2;

    // per-item control handed from the top level to one scan path
    typedef struct packed {
        logic       byte_en;   // item carries a byte for this path
        logic       end_en;    // item ends the text and this path is active
        logic       clear;     // item ends the text, drop all stream state
        logic [7:0] chr;
    } scan_ctl_t;

    function automatic logic is_word_byte(input logic [7:0] c);
        return (c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]}) ||
               (c == CHAR_UNDERSCORE) || (c == CHAR_PERCENT);
    endfunction

endpackage

FILE: rtl/ims_word_scan.sv
// ----------------------------------------------------------------------------
// ims_word_scan
// identifier tokenizer with string skipping and whole-token name compare
// ----------------------------------------------------------------------------
module ims_word_scan #(
    parameter int NAME_MAX = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ims_pkg::scan_ctl_t    ctl,
    input  logic [127:0]          name_chars,
    input  logic [4:0]            name_len,
    output logic                  hit
);

    localparam int DEPTH = (NAME_MAX < ims_pkg::NAME_BYTES) ? NAME_MAX : ims_pkg::NAME_BYTES;
    localparam int CW    = $clog2(NAME_MAX + 1);

    logic          in_str_reg, in_str_next;
    logic          skip_reg, skip_next;
    logic [CW-1:0] count_reg, count_next;
    logic          too_long_reg, too_long_next;
    logic [7:0]    tok_reg [DEPTH];
    logic [7:0]    tok_next [DEPTH];

    logic          word_c;
    logic          append;
    logic          byte_close;
    logic [CW-1:0] count_v;
    logic          too_long_v;
    logic          mismatch;

    always_comb
    begin
        word_c     = ims_pkg::is_word_byte(ctl.chr);
        append     = 1'b0;
        byte_close = 1'b0;
        in_str_next   = in_str_reg;
        skip_next     = skip_reg;
        too_long_v    = too_long_reg;

        if (ctl.byte_en)
        begin
            if (in_str_reg)
            begin
                if (skip_reg)
                    skip_next = 1'b0;
                else if (ctl.chr == ims_pkg::CHAR_QUOTE)
                    in_str_next = 1'b0;
                else if (ctl.chr == ims_pkg::CHAR_BACKSLASH)
                    skip_next = 1'b1;
            end
            else if (word_c)
            begin
                if (32'(count_reg) < NAME_MAX)
                    append = 1'b1;
                else
                    too_long_v = 1'b1;
            end
            else
            begin
                byte_close = 1'b1;
                if (ctl.chr == ims_pkg::CHAR_QUOTE)
                begin
                    in_str_next = 1'b1;
                    skip_next   = 1'b0;
                end
            end
        end

        // token as it stands after this byte
        count_v = count_reg + CW'(append);
        for (int i = 0; i < DEPTH; i++)
            tok_next[i] = (append && (count_reg == CW'(i))) ? ctl.chr : tok_reg[i];

        mismatch = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            if ((i < int'(name_len)) && (tok_next[i] != name_chars[8*i +: 8]))
                mismatch = 1'b1;

        hit = (byte_close || ctl.end_en) && !too_long_v && (count_v != '0) &&
              (32'(count_v) == 32'(name_len)) && !mismatch;

        if (ctl.clear)
        begin
            in_str_next   = 1'b0;
            skip_next     = 1'b0;
            count_next    = '0;
            too_long_next = 1'b0;
        end
        else if (byte_close)
        begin
            count_next    = '0;
            too_long_next = 1'b0;
        end
        else
        begin
            count_next    = count_v;
            too_long_next = too_long_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_str_reg   <= 1'b0;
            skip_reg     <= 1'b0;
            count_reg    <= '0;
            too_long_reg <= 1'b0;
        end
        else
        begin
            in_str_reg   <= in_str_next;
            skip_reg     <= skip_next;
            count_reg    <= count_next;
            too_long_reg <= too_long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            tok_reg[i] <= tok_next[i];
    end

endmodule

FILE: rtl/ims_plain_scan.sv
// ----------------------------------------------------------------------------
// ims_plain_scan
// backslash-unescaping byte history with substring compare against the name
// ----------------------------------------------------------------------------
module ims_plain_scan #(
    parameter int NAME_MAX = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ims_pkg::scan_ctl_t    ctl,
    input  logic [127:0]          name_chars,
    input  logic [4:0]            name_len,
    output logic                  hit
);

    localparam int DEPTH = (NAME_MAX < ims_pkg::NAME_BYTES) ? NAME_MAX : ims_pkg::NAME_BYTES;
    localparam int RW    = $clog2(DEPTH + 1);

    logic          pending_reg, pending_next;
    logic [RW-1:0] rcount_reg, rcount_next;
    logic [7:0]    hist_reg [DEPTH];   // index 0 holds the newest byte
    logic [7:0]    hist_next [DEPTH];

    logic          push_en;
    logic [7:0]    push_val;
    logic [RW-1:0] rcount_inc;
    logic          mismatch;

    always_comb
    begin
        // at most one byte enters the history per item; a dangling backslash
        // at the end of the text enters as itself
        push_en  = (ctl.byte_en && (pending_reg || (ctl.chr != ims_pkg::CHAR_BACKSLASH) ||
                                    ctl.end_en)) ||
                   (!ctl.byte_en && ctl.end_en && pending_reg);
        push_val = ctl.byte_en ? ctl.chr : ims_pkg::CHAR_BACKSLASH;

        hist_next[0] = push_en ? push_val : hist_reg[0];
        for (int k = 1; k < DEPTH; k++)
            hist_next[k] = push_en ? hist_reg[k-1] : hist_reg[k];

        rcount_inc = (32'(rcount_reg) < DEPTH) ? rcount_reg + RW'(1) : rcount_reg;

        // name byte i lines up with history slot len-1-i
        mismatch = 1'b0;
        for (int k = 0; k < DEPTH; k++)
            for (int i = 0; i < DEPTH; i++)
                if ((int'(name_len) == k + i + 1) && (hist_next[k] != name_chars[8*i +: 8]))
                    mismatch = 1'b1;

        hit = push_en && (32'(rcount_inc) >= 32'(name_len)) && !mismatch;

        if (ctl.clear)
        begin
            pending_next = 1'b0;
            rcount_next  = '0;
        end
        else
        begin
            pending_next = ctl.byte_en ? (!pending_reg && (ctl.chr == ims_pkg::CHAR_BACKSLASH))
                                       : pending_reg;
            rcount_next  = push_en ? rcount_inc : rcount_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            rcount_reg  <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            rcount_reg  <= rcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
            hist_reg[k] <= hist_next[k];
    end

endmodule

FILE: rtl/identifier_mention_scanner.sv
// ----------------------------------------------------------------------------
// identifier_mention_scanner
// reports at the end of a text whether a configured name is mentioned in it
// ----------------------------------------------------------------------------
// Takes one text byte per item and sustains one item per clock cycle: each
// item is held in an input register while the token compare and the
// substring compare (both parallel against up to 16 name bytes) update the
// scan state, and the answer for a last item is loaded into the output
// register as that item leaves the input register. The input stage only holds when a last
// item finds the output register still full. A name made only of letters,
// digits, underscore and percent must equal a whole identifier outside string
// literals; any other name is searched as a substring after backslash
// unescaping. Name registers may be written only between texts.
// ----------------------------------------------------------------------------
`include "identifier_mention_scanner_macros.svh"

module identifier_mention_scanner #(
    parameter int NAME_MAX = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] text_char
    input  logic        s_tuser,     // [0] no_char
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata      // [0] mentioned, [7:1] zero
);

    logic [63:0] name_low_reg;
    logic [63:0] name_high_reg;
    logic [4:0]  name_len_reg;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_nochar_reg;
    logic        in_last_reg;

    logic        found_reg, found_next;
    logic        out_valid_reg, out_valid_next;
    logic        mentioned_reg, mentioned_next;

    logic [127:0] name_chars;
    logic         usable;
    logic         word_mode;
    logic         go;
    logic         word_hit;
    logic         plain_hit;
    logic         result;

    ims_pkg::scan_ctl_t word_ctl;
    ims_pkg::scan_ctl_t plain_ctl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_low_reg  <= '0;
            name_high_reg <= '0;
            name_len_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                ims_pkg::REG_NAME_LOW:  name_low_reg  <= cfg_wdata;
                ims_pkg::REG_NAME_HIGH: name_high_reg <= cfg_wdata;
                ims_pkg::REG_NAME_LEN:  name_len_reg  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        name_chars = {name_high_reg, name_low_reg};
        usable     = (name_len_reg != 5'd0) && (32'(name_len_reg) <= ims_pkg::NAME_BYTES) &&
                     (32'(name_len_reg) <= NAME_MAX);
        word_mode  = usable;
        for (int i = 0; i < ims_pkg::NAME_BYTES; i++)
            if ((i < int'(name_len_reg)) && !ims_pkg::is_word_byte(name_chars[8*i +: 8]))
                word_mode = 1'b0;
    end

    // a last item may only leave the input stage into a free output register
    assign go       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || go;

    always_comb
    begin
        word_ctl.byte_en  = go && usable && word_mode && !in_nochar_reg;
        word_ctl.end_en   = go && usable && word_mode && in_last_reg;
        word_ctl.clear    = go && in_last_reg;
        word_ctl.chr      = in_char_reg;

        plain_ctl.byte_en = go && usable && !word_mode && !in_nochar_reg;
        plain_ctl.end_en  = go && usable && !word_mode && in_last_reg;
        plain_ctl.clear   = go && in_last_reg;
        plain_ctl.chr     = in_char_reg;
    end

    ims_word_scan #(
        .NAME_MAX   (NAME_MAX)
    ) u_word_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (word_ctl),
        .name_chars (name_chars),
        .name_len   (name_len_reg),
        .hit        (word_hit)
    );

    ims_plain_scan #(
        .NAME_MAX   (NAME_MAX)
    ) u_plain_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (plain_ctl),
        .name_chars (name_chars),
        .name_len   (name_len_reg),
        .hit        (plain_hit)
    );

    always_comb
    begin
        result         = usable && (found_reg || word_hit || plain_hit);
        in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (go ? 1'b0 : in_valid_reg);
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        mentioned_next = mentioned_reg;

        if (go)
            found_next = in_last_reg ? 1'b0 : (found_reg || word_hit || plain_hit);

        if (go && in_last_reg)
        begin
            out_valid_next = 1'b1;
            mentioned_next = result;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg   <= s_tdata;
            in_nochar_reg <= s_tuser;
            in_last_reg   <= s_tlast;
        end
        mentioned_reg <= mentioned_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, mentioned_reg};

    `IMS_ASSERT_NEXT(a_last_gives_result, clk, rst_n, go && in_last_reg, out_valid_reg,
        "processed last item did not load the output register")
    `IMS_ASSERT_NEXT(a_found_cleared, clk, rst_n, go && in_last_reg, !found_reg,
        "found flag survived the end of a text")
    `IMS_ASSERT_NOW(a_hit_needs_item, clk, rst_n, word_hit || plain_hit, go && usable,
        "match reported without an item in process")
    `IMS_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_reg && !m_tready && in_last_reg, !go,
        "pending result would be overwritten")

endmodule

FILE: tb/identifier_mention_scanner_tb.sv
// ----------------------------------------------------------------------------
// identifier_mention_scanner_tb
// self-checking bench for the identifier mention scanner
// ----------------------------------------------------------------------------
// Streams short texts into the scanner and predicts each answer with a local
// model of both search modes: whole identifier tokens outside string literals
// and a plain substring search after backslash unescaping. It runs a few
// directed texts first, then random texts under many name settings. The names
// are short, long, empty and oversized. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module identifier_mention_scanner_tb;

    localparam int ITEM_TARGET = 1850;
    localparam int CALM_FROM   = 1600;

    class mention_scoreboard;
        bit [63:0] name_lo;
        bit [63:0] name_hi;
        bit [4:0]  name_len;
        bit        in_literal;
        bit        skip_one;
        bit [7:0]  token_chars[ims_pkg::NAME_BYTES];
        int        token_len;
        bit        token_overflow;
        bit        escape_open;
        bit [7:0]  tail_chars[ims_pkg::NAME_BYTES];
        int        tail_fill;
        bit        seen;
        bit        answers[$];
        int        errors;
        int        results_checked;
        int        hits;

        function bit ident_char(bit [7:0] c);
            return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
                   (c >= 8'h30 && c <= 8'h39) || c == ims_pkg::CHAR_UNDERSCORE ||
                   c == ims_pkg::CHAR_PERCENT;
        endfunction

        function bit [7:0] name_char(int i);
            return (i < 8) ? name_lo[8*i +: 8] : name_hi[8*(i-8) +: 8];
        endfunction

        function bit name_in_range();
            return name_len >= 1 && name_len <= ims_pkg::NAME_BYTES;
        endfunction

        function bit name_is_ident();
            for (int i = 0; i < name_len && i < ims_pkg::NAME_BYTES; i++)
                if (!ident_char(name_char(i)))
                    return 1'b0;
            return 1'b1;
        endfunction

        function void close_ident();
            bit match;
            match = !token_overflow && token_len == name_len && token_len > 0;
            for (int i = 0; i < token_len; i++)
                if (token_chars[i] != name_char(i))
                    match = 1'b0;
            if (match)
                seen = 1'b1;
            token_len = 0;
            token_overflow = 1'b0;
        endfunction

        function void ident_step(bit [7:0] c);
            if (in_literal)
            begin
                if (skip_one)
                    skip_one = 1'b0;
                else if (c == ims_pkg::CHAR_QUOTE)
                    in_literal = 1'b0;
                else if (c == ims_pkg::CHAR_BACKSLASH)
                    skip_one = 1'b1;
            end
            else if (ident_char(c))
            begin
                if (token_len < ims_pkg::NAME_BYTES)
                begin
                    token_chars[token_len] = c;
                    token_len++;
                end
                else
                    token_overflow = 1'b1;
            end
            else
            begin
                close_ident();
                if (c == ims_pkg::CHAR_QUOTE)
                begin
                    in_literal = 1'b1;
                    skip_one = 1'b0;
                end
            end
        endfunction

        function void tail_push(bit [7:0] c);
            int  n;
            bit  match;
            n = name_len;
            for (int i = 0; i < ims_pkg::NAME_BYTES - 1; i++)
                tail_chars[i] = tail_chars[i+1];
            tail_chars[ims_pkg::NAME_BYTES-1] = c;
            if (tail_fill < ims_pkg::NAME_BYTES)
                tail_fill++;
            if (tail_fill < n)
                return;
            match = 1'b1;
            for (int i = 0; i < n; i++)
                if (tail_chars[ims_pkg::NAME_BYTES-n+i] != name_char(i))
                    match = 1'b0;
            if (match)
                seen = 1'b1;
        endfunction

        function void plain_step(bit [7:0] c);
            if (escape_open)
            begin
                escape_open = 1'b0;
                tail_push(c);
            end
            else if (c == ims_pkg::CHAR_BACKSLASH)
                escape_open = 1'b1;
            else
                tail_push(c);
        endfunction

        function void clear_text();
            in_literal = 1'b0;
            skip_one = 1'b0;
            token_len = 0;
            token_overflow = 1'b0;
            escape_open = 1'b0;
            tail_fill = 0;
            seen = 1'b0;
            for (int i = 0; i < ims_pkg::NAME_BYTES; i++)
            begin
                token_chars[i] = 8'h00;
                tail_chars[i] = 8'h00;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                ims_pkg::REG_NAME_LOW:  name_lo = val;
                ims_pkg::REG_NAME_HIGH: name_hi = val;
                ims_pkg::REG_NAME_LEN:  name_len = val[4:0];
                default: ;
            endcase
        endfunction

        function void note_item(bit [7:0] c, bit no_char, bit lst);
            bit usable;
            bit ident;
            usable = name_in_range();
            ident = usable && name_is_ident();
            if (usable && !no_char)
            begin
                if (ident)
                    ident_step(c);
                else
                    plain_step(c);
            end
            if (!lst)
                return;
            if (usable)
            begin
                if (ident)
                    close_ident();
                else if (escape_open)
                begin
                    // a backslash at the very end stays as a plain char
                    escape_open = 1'b0;
                    tail_push(ims_pkg::CHAR_BACKSLASH);
                end
            end
            answers.insert(answers.size(), usable && seen);
            clear_text();
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(logic [7:0] data);
            bit want;
            if (answers.size() == 0)
            begin
                report($sformatf("result %h with no text pending", data));
                return;
            end
            want = answers.pop_front();
            results_checked++;
            if (want)
                hits++;
            if (data !== {7'b0, want})
                report($sformatf("mentioned got %h want %0d", data, want));
        endtask

        function int pending();
            return answers.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;

    mention_scoreboard sb = new();

    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    bit       calm = 1'b0;
    int       stall_left = 0;
    int       random_items = 0;
    int       texts_sent = 0;
    int       phases = 0;
    bit [7:0] name_buf[ims_pkg::NAME_BYTES];
    int       name_used = 0;
    bit       name_plain = 1'b0;

    identifier_mention_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side stalls in random bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < recv_idle_pct)
        begin
            stall_left = $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // inputs are noted before results so one edge never races itself
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tdata, s_tuser, s_tlast);
            if (m_tvalid === 1'b1 && m_tready)
                sb.check_result(m_tdata);
        end
    end

    task automatic send_item(bit [7:0] c, bit no_char, bit lst);
        int gap;
        if (!calm && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= no_char;
        s_tlast <= lst;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0, i == s.len() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // unused name bytes get random filler, the scanner must ignore them
    task automatic configure(bit [4:0] len);
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] len_word;
        drain();
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        len_word = {$urandom, $urandom};
        len_word[4:0] = len;
        for (int i = 0; i < name_used; i++)
        begin
            if (i < 8)
                lo[8*i +: 8] = name_buf[i];
            else
                hi[8*(i-8) +: 8] = name_buf[i];
        end
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= ims_pkg::REG_NAME_LOW;
        cfg_wdata <= lo;
        @(negedge clk);
        cfg_index <= ims_pkg::REG_NAME_HIGH;
        cfg_wdata <= hi;
        @(negedge clk);
        cfg_index <= ims_pkg::REG_NAME_LEN;
        cfg_wdata <= len_word;
        @(negedge clk);
        cfg_wen <= 1'b0;
        sb.write_reg(ims_pkg::REG_NAME_LOW, lo);
        sb.write_reg(ims_pkg::REG_NAME_HIGH, hi);
        sb.write_reg(ims_pkg::REG_NAME_LEN, len_word);
    endtask

    task automatic set_name(string s, bit plain);
        name_used = s.len();
        for (int i = 0; i < name_used; i++)
            name_buf[i] = s[i];
        name_plain = plain;
        configure(5'(name_used));
    endtask

    // small alphabet so near misses are common
    function automatic bit [7:0] rand_ident_char();
        case ($urandom_range(0, 7))
            0: return 8'h61 + 8'($urandom_range(0, 25));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            2: return 8'h30 + 8'($urandom_range(0, 9));
            3: return ims_pkg::CHAR_UNDERSCORE;
            4: return ims_pkg::CHAR_PERCENT;
            default: return 8'h61 + 8'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic bit [7:0] rand_other_char();
        case ($urandom_range(0, 6))
            0: return 8'($urandom_range(0, 255));
            1: return ims_pkg::CHAR_BACKSLASH;
            2: return ims_pkg::CHAR_QUOTE;
            3: return 8'h20;
            4: return 8'h00;
            5: return 8'hff;
            default: return 8'h2e;
        endcase
    endfunction

    function automatic void pick_name(bit plain, int len);
        name_used = len;
        name_plain = plain;
        for (int i = 0; i < len; i++)
        begin
            if (plain && $urandom_range(0, 2) == 0)
                name_buf[i] = rand_other_char();
            else
                name_buf[i] = rand_ident_char();
        end
        if (plain)
            name_buf[$urandom_range(0, len - 1)] = rand_other_char();
    endfunction

    function automatic void append_entry(ref bit [8:0] q[$], input bit [8:0] entry);
        q.insert(q.size(), entry);
    endfunction

    function automatic void push_name(ref bit [8:0] q[$], input int upto);
        for (int i = 0; i < upto; i++)
        begin
            if (name_plain && ($urandom_range(0, 3) == 0 ||
                (name_buf[i] == ims_pkg::CHAR_BACKSLASH && $urandom_range(0, 1) == 1)))
                append_entry(q, {1'b0, ims_pkg::CHAR_BACKSLASH});
            append_entry(q, {1'b0, name_buf[i]});
        end
    endfunction

    // bit 8 of each entry marks an item that carries no char
    task automatic send_random_text();
        bit [8:0] q[$];
        int       target;
        if ($urandom_range(0, 19) == 0)
            append_entry(q, {1'b1, 8'($urandom)});
        else
        begin
            target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48)
                                                 : $urandom_range(1, 20);
            while (q.size() < target)
            begin
                case ($urandom_range(0, 11))
                    0, 1, 2: push_name(q, name_used);
                    3: push_name(q, $urandom_range(1, name_used));
                    4:
                    begin
                        push_name(q, name_used);
                        append_entry(q, {1'b0, rand_ident_char()});
                    end
                    5: repeat ($urandom_range(1, 3)) append_entry(q, {1'b0, rand_ident_char()});
                    6:
                    begin
                        case ($urandom_range(0, 3))
                            0: append_entry(q, {1'b0, 8'h20});
                            1: append_entry(q, {1'b0, 8'h3b});
                            2: append_entry(q, {1'b0, 8'h28});
                            default: append_entry(q, {1'b0, 8'h0a});
                        endcase
                    end
                    7: append_entry(q, {1'b0, ims_pkg::CHAR_QUOTE});
                    8: append_entry(q, {1'b0, ims_pkg::CHAR_BACKSLASH});
                    9: append_entry(q, {1'b0, 8'($urandom_range(0, 255))});
                    10: append_entry(q, {1'b1, 8'($urandom)});
                    default:
                    begin
                        append_entry(q, {1'b0, ims_pkg::CHAR_QUOTE});
                        push_name(q, name_used);
                        append_entry(q, {1'b0, ims_pkg::CHAR_QUOTE});
                    end
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                append_entry(q, {1'b1, 8'($urandom)});
        end
        foreach (q[i])
            send_item(q[i][7:0], q[i][8], i == q.size() - 1);
        random_items += q.size();
        texts_sent++;
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    initial
    begin
        int budget;
        int kind;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // empty name from reset answers no
        send_string("ab");

        set_name("foo", 1'b0);
        send_string("foo");
        send_string("foox");
        send_string("\"foo\"");
        send_string("\"\\\"foo");
        send_item(8'hff, 1'b1, 1'b1);
        send_item("f", 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_string("oo");

        // substring mode: escaped char and a trailing backslash
        set_name("a.b", 1'b1);
        send_string("a\\.b");
        set_name("b\\", 1'b1);
        send_string("ab\\");

        while (random_items < ITEM_TARGET)
        begin
            kind = (phases < 7) ? phases : $urandom_range(7, 16);
            case (kind)
                0: pick_name(1'b0, ims_pkg::NAME_BYTES);
                1: pick_name(1'b1, ims_pkg::NAME_BYTES);
                2: pick_name(1'b0, 1);
                3: pick_name(1'b1, 1);
                default: pick_name($urandom_range(0, 1),
                                   $urandom_range(1, ims_pkg::NAME_BYTES));
            endcase
            // empty and oversized lengths never match
            case (kind)
                4: configure(5'd0);
                5: configure(5'd17);
                6: configure(5'd31);
                7: configure(5'($urandom_range(17, 31)));
                default: configure(5'(name_used));
            endcase
            send_idle_pct = pick_pct();
            recv_idle_pct = pick_pct();
            budget = random_items + ((kind >= 4 && kind <= 7) ? $urandom_range(20, 40)
                                                             : $urandom_range(60, 180));
            while (random_items < budget && random_items < ITEM_TARGET)
            begin
                send_random_text();
                if ($urandom_range(0, 14) == 0)
                    drain();
                if (random_items >= CALM_FROM)
                    calm = 1'b1;
            end
            phases++;
        end
        drain();

        $display("covered %0d random texts (%0d items) over %0d name settings",
                 texts_sent, random_items, phases);
        $display("checked %0d answers, %0d of them mentions",
                 sb.results_checked, sb.hits);
        if (sb.errors == 0)
            $display("identifier_mention_scanner_tb: PASS");
        else
            $display("identifier_mention_scanner_tb: FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timed out waiting on the scanner");
        $display("identifier_mention_scanner_tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ims_pkg.sv
rtl/ims_word_scan.sv
rtl/ims_plain_scan.sv
rtl/identifier_mention_scanner.sv
tb/identifier_mention_scanner_tb.sv
